// ----- design/lfd_pkg.sv -----
`timescale 1ns / 1ps

package lfd_pkg;

   // default size of the payload buffer in bytes
   localparam int PAYLOAD_DEPTH_DEFAULT = 256;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // field widths
   localparam int BYTE_W = 8;
   localparam int OP_W = 2;
   localparam int CSR_INDEX_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
   localparam logic [OP_W-1:0] OP_READ    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVALID_CODE = 2'd2;

   // configuration reset values
   localparam logic [BYTE_W-1:0] START_CODE_RESET   = 8'd126;
   localparam logic [BYTE_W-1:0] END_CODE_RESET     = 8'd127;
   localparam logic [BYTE_W-1:0] INVALID_CODE_RESET = 8'd255;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_LEN   = 3'd1,
      PH_DATA  = 3'd2,
      PH_END   = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_TAKEN    = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_DROP     = 3'd2,
      ST_IGNORE   = 3'd3,
      ST_READ     = 3'd4
   } status_type;

   // one classified item on its way from front to back
   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   frame_length;
      phase_type           phase;
      logic                mem_write;
      logic                mem_read;
      logic [BYTE_W-1:0]   addr;
      logic [BYTE_W-1:0]   wdata;
   } entry_type;

endpackage

// ----- design/lfd_front.sv -----
`timescale 1ns / 1ps

module lfd_front import lfd_pkg::*; #(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata,
   input  logic                   accept,
   input  logic [OP_W-1:0]        op,
   input  logic [BYTE_W-1:0]      rx_byte,
   input  logic [BYTE_W-1:0]      read_index,
   output entry_type              entry
);

   localparam logic [BYTE_W:0] DEPTH_LIMIT = (BYTE_W+1)'(PAYLOAD_DEPTH);

   logic [BYTE_W-1:0] start_code_ff;
   logic [BYTE_W-1:0] end_code_ff;
   logic [BYTE_W-1:0] invalid_code_ff;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [BYTE_W-1:0] bytes_left_ff;
   logic [BYTE_W-1:0] bytes_left_in;
   logic [BYTE_W-1:0] payload_len_ff;
   logic [BYTE_W-1:0] payload_len_in;

   logic              len_reject;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff   <= START_CODE_RESET;
         end_code_ff     <= END_CODE_RESET;
         invalid_code_ff <= INVALID_CODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_CODE:   start_code_ff   <= csr_wdata;
            CSR_END_CODE:     end_code_ff     <= csr_wdata;
            CSR_INVALID_CODE: invalid_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // length byte that cannot open a frame
   assign len_reject = (rx_byte == invalid_code_ff) || (rx_byte == start_code_ff) ||
                       (rx_byte == end_code_ff) || ({1'b0, rx_byte} > DEPTH_LIMIT);

   // classify the item and work out the next receiver state
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      payload_len_in = payload_len_ff;
      entry.status    = ST_IGNORE;
      entry.mem_write = 1'b0;
      entry.mem_read  = 1'b0;
      entry.addr      = '0;
      entry.wdata     = rx_byte;
      unique case (op)
         OP_BYTE: begin
            unique case (phase_ff)
               PH_START: begin
                  if (rx_byte == start_code_ff) begin
                     phase_in     = PH_LEN;
                     entry.status = ST_TAKEN;
                  end
               end
               PH_LEN: begin
                  payload_len_in = rx_byte;
                  if (len_reject) begin
                     phase_in      = PH_START;
                     bytes_left_in = '0;
                     entry.status  = ST_DROP;
                  end else begin
                     bytes_left_in = rx_byte;
                     phase_in      = (rx_byte == '0) ? PH_END : PH_DATA;
                     entry.status  = ST_TAKEN;
                  end
               end
               PH_DATA: begin
                  entry.mem_write = 1'b1;
                  entry.addr      = payload_len_ff - bytes_left_ff;
                  bytes_left_in   = bytes_left_ff - 8'd1;
                  if (bytes_left_ff == 8'd1) begin
                     phase_in = PH_END;
                  end
                  entry.status = ST_TAKEN;
               end
               PH_END: begin
                  if (rx_byte == end_code_ff) begin
                     phase_in     = PH_DONE;
                     entry.status = ST_COMPLETE;
                  end else begin
                     phase_in     = PH_START;
                     entry.status = ST_DROP;
                  end
               end
               PH_DONE: begin
                  entry.status = ST_IGNORE;
               end
               default: begin
                  phase_in     = PH_START;
                  entry.status = ST_IGNORE;
               end
            endcase
         end
         OP_READ: begin
            entry.status   = ST_READ;
            entry.addr     = read_index;
            entry.mem_read = (phase_ff == PH_DONE) && (read_index < payload_len_ff) &&
                             ({1'b0, read_index} < DEPTH_LIMIT);
         end
         OP_RESTART: begin
            phase_in       = PH_START;
            bytes_left_in  = '0;
            payload_len_in = '0;
            entry.status   = ST_TAKEN;
         end
         default: begin
            entry.status = ST_IGNORE;
         end
      endcase
      entry.frame_length = payload_len_in;
      entry.phase        = phase_in;
   end

   // receiver state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         bytes_left_ff  <= '0;
         payload_len_ff <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         payload_len_ff <= payload_len_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("payload phase with no bytes left");
   a_done_len_fits: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> ({1'b0, payload_len_ff} <= DEPTH_LIMIT && bytes_left_ff == '0))
      else $error("completed frame length out of range");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      accept && entry.mem_write |-> {1'b0, entry.addr} < DEPTH_LIMIT)
      else $error("payload write beyond buffer");
`endif

endmodule

// ----- design/lfd_queue.sv -----
`timescale 1ns / 1ps

module lfd_queue import lfd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count out of range");
`endif

endmodule

// ----- design/lfd_back.sv -----
`timescale 1ns / 1ps

module lfd_back import lfd_pkg::*; #(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              entry_valid,
   input  entry_type         entry,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [BYTE_W-1:0] rsp_read_data,
   output logic [BYTE_W-1:0] rsp_frame_length,
   output logic [2:0]        rsp_receiver_phase
);

   localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

   logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];
   logic [ADDR_W-1:0] mem_addr;

   logic              rsp_valid_ff;
   status_type        status_ff;
   logic [BYTE_W-1:0] frame_length_ff;
   phase_type         phase_ff;
   logic              read_hit_ff;
   logic [BYTE_W-1:0] read_data_ff;

   // take the next entry when the output register is free or being drained
   assign pop      = entry_valid && (!rsp_valid_ff || !rsp_stall);
   assign mem_addr = entry.addr[ADDR_W-1:0];

   // payload buffer, at most one write or one read per entry
   always_ff @(posedge clock) begin
      if (pop && entry.mem_write) begin
         payload_mem[mem_addr] <= entry.wdata;
      end
      if (pop && entry.mem_read) begin
         read_data_ff <= payload_mem[mem_addr];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff       <= entry.status;
         frame_length_ff <= entry.frame_length;
         phase_ff        <= entry.phase;
         read_hit_ff     <= entry.mem_read;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_read_data      = read_hit_ff ? read_data_ff : '0;
   assign rsp_frame_length   = frame_length_ff;
   assign rsp_receiver_phase = phase_ff;

`ifndef NO_ASSERTIONS
   a_hit_is_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && read_hit_ff |-> status_ff == ST_READ && phase_ff == PH_DONE)
      else $error("buffer read outside a completed frame");
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      pop |-> !(entry.mem_write && entry.mem_read))
      else $error("write and read in one entry");
   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_read_data))
      else $error("transfer lost under stall");
`endif

endmodule

// ----- design/length_framed_byte_deframer.sv -----
`timescale 1ns / 1ps

// Deframer for a byte stream framed as start code, length byte, payload bytes
// and end code. One request is taken per clock while req_stall is low: a
// received byte, a read of the stored payload by index, or a restart. Every
// request gives exactly one response, in order, with status, read data,
// current frame length and receiver phase. The front updates the receiver
// state in the cycle of the transfer; the back writes or reads the payload
// buffer (one port) and registers the response. A request passes the queue
// slot, then the output register; responses flow one per clock while rsp_stall
// is low. A two-entry queue between the two halves lets requests go on while
// a response is stalled, until the queue is full. The payload buffer is not
// cleared after reset; reads only reach bytes written by the completed frame.

module length_framed_byte_deframer import lfd_pkg::*; #(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic [BYTE_W-1:0]      req_read_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [BYTE_W-1:0]      rsp_read_data,
   output logic [BYTE_W-1:0]      rsp_frame_length,
   output logic [2:0]             rsp_receiver_phase
);

   logic      req_accept;
   logic      queue_full;
   logic      queue_not_empty;
   logic      queue_pop;
   entry_type front_entry;
   entry_type back_entry;

   // request transfer while the queue has room
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   lfd_front #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (req_accept),
      .op         (req_op),
      .rx_byte    (req_rx_byte),
      .read_index (req_read_index),
      .entry      (front_entry)
   );

   lfd_queue #(
      .DEPTH (QUEUE_DEPTH_DEFAULT)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .pop_entry  (back_entry)
   );

   lfd_back #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .entry_valid        (queue_not_empty),
      .entry              (back_entry),
      .pop                (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_data      (rsp_read_data),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_receiver_phase (rsp_receiver_phase)
   );

endmodule

// ----- test/deframer_checker.sv -----
`timescale 1ns / 1ps

module deframer_checker import lfd_pkg::*; #(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic [BYTE_W-1:0]      req_read_index,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [2:0]             rsp_status,
   input  logic [BYTE_W-1:0]      rsp_read_data,
   input  logic [BYTE_W-1:0]      rsp_frame_length,
   input  logic [2:0]             rsp_receiver_phase,
   output int                     mismatch_count,
   output int                     outstanding
);

   localparam int PRINT_LIMIT = 40;

   typedef struct {
      status_type        status;
      logic [BYTE_W-1:0] read_data;
      logic [BYTE_W-1:0] frame_length;
      phase_type         phase;
   } frame_answer_type;

   // receiver copy: codes, framing state and the payload buffer
   logic [BYTE_W-1:0] start_code;
   logic [BYTE_W-1:0] end_code;
   logic [BYTE_W-1:0] invalid_code;
   phase_type         rx_phase;
   logic [BYTE_W-1:0] bytes_left;
   logic [BYTE_W-1:0] payload_len;
   logic [BYTE_W-1:0] payload_copy [PAYLOAD_DEPTH];

   frame_answer_type pending_answers [$];
   int               answers_seen = 0;

   initial begin
      mismatch_count = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string field, input logic [BYTE_W-1:0] got,
                                  input logic [BYTE_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("checker: response %0d %s got %0d want %0d", answers_seen, field, got, want);
      mismatch_count++;
   endtask

   // advance the receiver by one transfer and work out its response
   function automatic frame_answer_type deframe(input logic [OP_W-1:0] op,
                                                input logic [BYTE_W-1:0] rx,
                                                input logic [BYTE_W-1:0] index);
      frame_answer_type  a;
      logic [BYTE_W-1:0] pos;
      a.status = ST_IGNORE;
      a.read_data = '0;
      case (op)
         OP_BYTE: begin
            case (rx_phase)
               PH_START: begin
                  if (rx == start_code) begin
                     rx_phase = PH_LEN;
                     a.status = ST_TAKEN;
                  end
               end
               PH_LEN: begin
                  // the length byte is kept even when it gets the frame dropped
                  payload_len = rx;
                  if (rx == invalid_code || rx == start_code || rx == end_code ||
                      int'(rx) > PAYLOAD_DEPTH) begin
                     rx_phase = PH_START;
                     bytes_left = '0;
                     a.status = ST_DROP;
                  end else begin
                     bytes_left = rx;
                     rx_phase = (rx == '0) ? PH_END : PH_DATA;
                     a.status = ST_TAKEN;
                  end
               end
               PH_DATA: begin
                  pos = payload_len - bytes_left;
                  if (int'(pos) < PAYLOAD_DEPTH)
                     payload_copy[pos] = rx;
                  bytes_left = bytes_left - 1'b1;
                  if (bytes_left == '0)
                     rx_phase = PH_END;
                  a.status = ST_TAKEN;
               end
               PH_END: begin
                  if (rx == end_code) begin
                     rx_phase = PH_DONE;
                     a.status = ST_COMPLETE;
                  end else begin
                     rx_phase = PH_START;
                     a.status = ST_DROP;
                  end
               end
               PH_DONE: a.status = ST_IGNORE;
               default: rx_phase = PH_START;
            endcase
         end
         OP_READ: begin
            a.status = ST_READ;
            if (rx_phase == PH_DONE && index < payload_len && int'(index) < PAYLOAD_DEPTH)
               a.read_data = payload_copy[index];
         end
         OP_RESTART: begin
            rx_phase = PH_START;
            bytes_left = '0;
            payload_len = '0;
            a.status = ST_TAKEN;
         end
         default: a.status = ST_IGNORE;
      endcase
      a.frame_length = payload_len;
      a.phase = rx_phase;
      return a;
   endfunction

   // compare finished transfers, track register writes, predict new transfers
   always @(posedge clock) begin : watch
      frame_answer_type want;
      if (reset) begin
         start_code = START_CODE_RESET;
         end_code = END_CODE_RESET;
         invalid_code = INVALID_CODE_RESET;
         rx_phase = PH_START;
         bytes_left = '0;
         payload_len = '0;
         for (int i = 0; i < PAYLOAD_DEPTH; i++)
            payload_copy[i] = '0;
         pending_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("unexpected, status", rsp_status, '0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch("frame_length", rsp_frame_length, want.frame_length);
               if (rsp_receiver_phase !== want.phase)
                  report_mismatch("receiver_phase", rsp_receiver_phase, want.phase);
            end
            answers_seen++;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_START_CODE:   start_code = csr_wdata;
               CSR_END_CODE:     end_code = csr_wdata;
               CSR_INVALID_CODE: invalid_code = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_answers.push_back(deframe(req_op, req_rx_byte, req_read_index));
      end
      outstanding <= pending_answers.size();
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb import lfd_pkg::*; ();

   localparam logic [OP_W-1:0]        OP_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int ITEM_TARGET = 1900;
   localparam int SEGMENTS = 6;
   localparam int HOLD_CYCLES = 250;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]      csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_op = OP_BYTE;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic [BYTE_W-1:0]      req_read_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_status;
   logic [BYTE_W-1:0]      rsp_read_data;
   logic [BYTE_W-1:0]      rsp_frame_length;
   logic [2:0]             rsp_receiver_phase;

   int mismatch_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int useful_items = 0;
   int rsp_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // codes currently loaded, used to build frames
   logic [BYTE_W-1:0] start_q = START_CODE_RESET;
   logic [BYTE_W-1:0] end_q = END_CODE_RESET;
   logic [BYTE_W-1:0] invalid_q = INVALID_CODE_RESET;

   length_framed_byte_deframer u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_rx_byte        (req_rx_byte),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_data      (rsp_read_data),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_receiver_phase (rsp_receiver_phase)
   );

   deframer_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_rx_byte        (req_rx_byte),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_data      (rsp_read_data),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_receiver_phase (rsp_receiver_phase),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // response side: random stall, plus two long hold-offs to back the block up
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         rsp_seen <= rsp_seen + 1;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall && (rsp_seen == 400 || rsp_seen == 1500)) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [BYTE_W-1:0] rand8();
      return 8'($urandom_range(255));
   endfunction

   // payload bytes are often one of the codes
   function automatic logic [BYTE_W-1:0] pick_byte();
      if ($urandom_range(4) != 0)
         return rand8();
      case ($urandom_range(2))
         0: return start_q;
         1: return end_q;
         default: return invalid_q;
      endcase
   endfunction

   // mostly short lengths, now and then up to the full buffer; avoid the codes
   function automatic logic [BYTE_W-1:0] pick_length();
      logic [BYTE_W-1:0] len;
      len = '0;
      for (int tries = 0; tries < 16; tries++) begin
         case ($urandom_range(19))
            0: len = rand8();
            1, 2, 3, 4, 5: len = 8'($urandom_range(40, 9));
            default: len = 8'($urandom_range(8));
         endcase
         if (len != start_q && len != end_q && len != invalid_q)
            return len;
      end
      return len;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_index(input logic [BYTE_W-1:0] len);
      if (len != '0 && $urandom_range(3) != 0)
         return 8'($urandom_range(int'(len) - 1));
      return rand8();
   endfunction

   // offer one transfer, with random idle cycles ahead of it
   task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] rx,
                            input logic [BYTE_W-1:0] index, input bit useful);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_rx_byte <= rx;
      req_read_index <= index;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      if (useful)
         useful_items++;
   endtask

   // let every response come back before touching the registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] inv);
      csr_we <= 1'b1;
      csr_index <= CSR_START_CODE;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_END_CODE;
      csr_wdata <= e;
      @(posedge clock);
      csr_index <= CSR_INVALID_CODE;
      csr_wdata <= inv;
      @(posedge clock);
      // index past the register list must change nothing
      csr_index <= CSR_SPARE;
      csr_wdata <= rand8();
      @(posedge clock);
      csr_we <= 1'b0;
      start_q = s;
      end_q = e;
      invalid_q = inv;
   endtask

   // frame with random content, usually well-formed, then reads and usually a restart
   task automatic send_frame();
      logic [BYTE_W-1:0] len;
      len = pick_length();
      send_item(OP_BYTE, start_q, rand8(), 1);
      send_item(OP_BYTE, len, rand8(), 1);
      for (int i = 0; i < int'(len); i++)
         send_item(OP_BYTE, pick_byte(), rand8(), 1);
      if ($urandom_range(9) == 0)
         send_item(OP_BYTE, pick_byte(), rand8(), 1);
      else
         send_item(OP_BYTE, end_q, rand8(), 1);
      repeat ($urandom_range(4))
         send_item(OP_READ, rand8(), pick_index(len), 1);
      if ($urandom_range(4) == 0)
         send_item(OP_BYTE, pick_byte(), rand8(), 0);
      if ($urandom_range(9) < 8)
         send_item(OP_RESTART, rand8(), rand8(), 1);
   endtask

   initial begin
      logic [BYTE_W-1:0] len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the reset codes
      send_item(OP_SPARE, 8'hFF, 8'hFF, 1);
      send_item(OP_BYTE, 8'h00, 8'h00, 1);
      send_item(OP_READ, 8'h00, 8'h00, 1);
      send_item(OP_BYTE, start_q, 8'h00, 1);
      send_item(OP_BYTE, 8'd3, 8'h00, 1);
      send_item(OP_BYTE, 8'h00, 8'h00, 1);
      send_item(OP_BYTE, 8'hFF, 8'h00, 1);
      send_item(OP_BYTE, 8'hA5, 8'h00, 1);
      send_item(OP_BYTE, end_q, 8'h00, 1);
      send_item(OP_READ, 8'h00, 8'd0, 1);
      send_item(OP_READ, 8'h00, 8'd2, 1);
      send_item(OP_READ, 8'h00, 8'd3, 1);
      send_item(OP_READ, 8'h00, 8'hFF, 1);
      send_item(OP_BYTE, start_q, 8'h00, 1);
      // zero length goes straight to the end code
      send_item(OP_RESTART, 8'hFF, 8'hFF, 1);
      send_item(OP_BYTE, start_q, 8'h00, 1);
      send_item(OP_BYTE, 8'd0, 8'h00, 1);
      send_item(OP_BYTE, end_q, 8'h00, 1);
      send_item(OP_READ, 8'h00, 8'd0, 1);
      // rejected lengths and a wrong end code
      send_item(OP_RESTART, 8'h00, 8'h00, 1);
      send_item(OP_BYTE, start_q, 8'h00, 1);
      send_item(OP_BYTE, invalid_q, 8'h00, 1);
      send_item(OP_BYTE, start_q, 8'h00, 1);
      send_item(OP_BYTE, end_q, 8'h00, 1);
      send_item(OP_BYTE, start_q, 8'h00, 1);
      send_item(OP_BYTE, 8'd1, 8'h00, 1);
      send_item(OP_BYTE, 8'h5A, 8'h00, 1);
      send_item(OP_BYTE, 8'h00, 8'h00, 1);

      // random part in segments, each with its own codes and idle mix
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         case (seg)
            0: load_codes(8'h00, 8'hFF, 8'h80);
            2: load_codes(8'hFF, 8'h00, 8'h00);
            4: load_codes(START_CODE_RESET, END_CODE_RESET, INVALID_CODE_RESET);
            default: load_codes(rand8(), rand8(), rand8());
         endcase
         case (seg / 2)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (useful_items < (seg + 1) * ITEM_TARGET / SEGMENTS) begin
            case ($urandom_range(9))
               0: begin
                  // noise: any op, any content
                  repeat ($urandom_range(4, 1))
                     send_item(OP_W'($urandom_range(3)), rand8(), rand8(), 0);
               end
               1: begin
                  // start code followed by a length that is one of the codes
                  send_item(OP_BYTE, start_q, rand8(), 1);
                  case ($urandom_range(2))
                     0: send_item(OP_BYTE, start_q, rand8(), 1);
                     1: send_item(OP_BYTE, end_q, rand8(), 1);
                     default: send_item(OP_BYTE, invalid_q, rand8(), 1);
                  endcase
               end
               2: begin
                  // frame cut short by a restart
                  len = pick_length();
                  send_item(OP_BYTE, start_q, rand8(), 1);
                  send_item(OP_BYTE, len, rand8(), 1);
                  repeat ($urandom_range(int'(len)))
                     send_item(OP_BYTE, pick_byte(), rand8(), 1);
                  send_item(OP_RESTART, rand8(), rand8(), 1);
               end
               default: send_frame();
            endcase
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ----- length_framed_byte_deframer.f -----
design/lfd_pkg.sv
design/lfd_front.sv
design/lfd_queue.sv
design/lfd_back.sv
design/length_framed_byte_deframer.sv
test/deframer_checker.sv
test/tb.sv
